// File: rtl/chbs_pkg.sv
// Shared types and constants for the chained hash bucket store.
// No dependencies; imported by every module of the block.
package chbs_pkg;

   localparam int KEY_PORT_W = 16;
   localparam int BKT_PORT_W = 3;
   localparam int POS_PORT_W = 4;
   localparam int LEN_PORT_W = 5;
   localparam int CNT_PORT_W = 3;
   localparam int TOT_PORT_W = 7;
   localparam int STATUS_W   = 2;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [LEN_PORT_W-1:0] longest_len;
      logic [CNT_PORT_W-1:0] longest_cnt;
      logic [LEN_PORT_W-1:0] shortest_len;
      logic [CNT_PORT_W-1:0] shortest_cnt;
   } stats_type;

endpackage

// File: rtl/chbs_mod_unit.sv
// Key-modulo-bucket-count unit: reciprocal multiply, then multiply back and subtract.
// Key, quotient and remainder are registered in that order. Depends on chbs_pkg.
module chbs_mod_unit #(
   parameter int BUCKETS = 7,
   parameter int KEY_W   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [KEY_W-1:0]           key,
   output logic                       done,
   output logic [$clog2(BUCKETS)-1:0] rem
);
   import chbs_pkg::*;

   localparam int BKT_W = $clog2(BUCKETS);
   localparam int SHIFT = KEY_W + BKT_W;
   localparam int RCP_W = KEY_W + 1;
   localparam int PRD_W = KEY_W + RCP_W;
   localparam longint RCP_L =
      ((longint'(1) << SHIFT) + longint'(BUCKETS - 1)) / longint'(BUCKETS);
   localparam logic [RCP_W-1:0] RCP  = RCP_W'(RCP_L);
   localparam logic [KEY_W-1:0] DIVR = KEY_W'(BUCKETS);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] quo_ff, quo_in;
   logic [BKT_W-1:0] rem_ff, rem_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [PRD_W-1:0] prod;
   logic [KEY_W-1:0] diff;

   // quotient is exact for every key of KEY_W bits
   assign prod = PRD_W'(key_ff) * PRD_W'(RCP);
   assign diff = key_ff - quo_ff * DIVR;

   always_comb begin
      key_in = key_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         key_in = key;
         cnt_in = 2'd2;
      end else if (cnt_ff == 2'd2) begin
         quo_in = KEY_W'(prod >> SHIFT);
         cnt_in = 2'd1;
      end else if (cnt_ff == 2'd1) begin
         rem_in = BKT_W'(diff);
         cnt_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      key_ff <= key_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = (cnt_ff == '0);
   assign rem  = rem_ff;

endmodule

// File: rtl/chbs_key_mem.sv
// Key storage: single-port synchronous RAM, one bucket's chain per row block.
// Depends on chbs_pkg.
module chbs_key_mem #(
   parameter int DEPTH = 112,
   parameter int KEY_W = 16
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [KEY_W-1:0]         wdata,
   output logic [KEY_W-1:0]         rdata
);
   import chbs_pkg::*;

   logic [KEY_W-1:0] mem_ff [DEPTH];
   logic [KEY_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rdata = rd_ff;

endmodule

// File: rtl/chbs_len_mem.sv
// Per-bucket chain length RAM with a valid bit per entry; invalid reads as zero.
// Depends on chbs_pkg.
module chbs_len_mem #(
   parameter int BUCKETS = 7,
   parameter int LEN_W   = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [$clog2(BUCKETS)-1:0] addr,
   input  logic                       we,
   input  logic [LEN_W-1:0]           wdata,
   output logic [LEN_W-1:0]           rdata
);
   import chbs_pkg::*;

   logic [LEN_W-1:0]   mem_ff [BUCKETS];
   logic [BUCKETS-1:0] vld_ff;
   logic [LEN_W-1:0]   rd_ff;
   logic               rdv_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rd_ff <= mem_ff[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rdv_ff <= 1'b0;
      end else begin
         if (we) begin
            vld_ff[addr] <= 1'b1;
         end
         rdv_ff <= vld_ff[addr];
      end
   end

   assign rdata = rdv_ff ? rd_ff : '0;

endmodule

// File: rtl/chbs_stats.sv
// Running longest/shortest chain statistics, fed one bucket length per cycle.
// Depends on chbs_pkg (stats_type).
module chbs_stats #(
   parameter int BUCKETS = 7,
   parameter int LEN_W   = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clr,
   input  logic                 sample,
   input  logic [LEN_W-1:0]     len,
   output chbs_pkg::stats_type  stats
);
   import chbs_pkg::*;

   localparam int CNT_W = $clog2(BUCKETS + 1);

   logic [LEN_W-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [CNT_W-1:0] hin_ff, hin_in, lon_ff, lon_in;
   logic             first_ff, first_in;

   always_comb begin
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      hin_in   = hin_ff;
      lon_in   = lon_ff;
      first_in = first_ff;
      if (clr) begin
         first_in = 1'b1;
      end else if (sample) begin
         if (first_ff) begin
            hi_in    = len;
            lo_in    = len;
            hin_in   = CNT_W'(1);
            lon_in   = CNT_W'(1);
            first_in = 1'b0;
         end else begin
            if (len > hi_ff) begin
               hi_in  = len;
               hin_in = CNT_W'(1);
            end else if (len == hi_ff) begin
               hin_in = hin_ff + CNT_W'(1);
            end
            if (len < lo_ff) begin
               lo_in  = len;
               lon_in = CNT_W'(1);
            end else if (len == lo_ff) begin
               lon_in = lon_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      hin_ff <= hin_in;
      lon_ff <= lon_in;
   end

   assign stats.longest_len  = LEN_PORT_W'(hi_ff);
   assign stats.longest_cnt  = CNT_PORT_W'(hin_ff);
   assign stats.shortest_len = LEN_PORT_W'(lo_ff);
   assign stats.shortest_cnt = CNT_PORT_W'(lon_ff);

endmodule

// File: rtl/chained_hash_bucket_store_top.sv
// Chained hash bucket store: top level, sequencer and result register.
// Depends on chbs_pkg, chbs_mod_unit, chbs_key_mem, chbs_len_mem, chbs_stats.
//
// Separate-chaining hash table. An insert transfer appends the key to the chain of
// bucket key mod BUCKETS; a read transfer returns the key at a bucket and chain
// position. Each item gives one result carrying the chain statistics after its update.
// One item is worked at a time: a new request is not taken until the last item's result
// has been loaded into the result register.
// The length memory has one read port, so the statistics scan reads one bucket length at
// a time; the residue unit works in steps (reciprocal multiply, then correction).
// A new request is taken while the previous result still waits on the response side.
// No clearing pass is needed after reset.
module chained_hash_bucket_store_top #(
   parameter int BUCKETS     = 7,
   parameter int CHAIN_DEPTH = 16,
   parameter int KEY_BITS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic [chbs_pkg::KEY_PORT_W-1:0]    req_key_in,
   input  logic [chbs_pkg::BKT_PORT_W-1:0]    req_bucket_sel,
   input  logic [chbs_pkg::POS_PORT_W-1:0]    req_position_sel,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [chbs_pkg::STATUS_W-1:0]      rsp_status,
   output logic [chbs_pkg::BKT_PORT_W-1:0]    rsp_bucket_out,
   output logic [chbs_pkg::POS_PORT_W-1:0]    rsp_position_out,
   output logic [chbs_pkg::KEY_PORT_W-1:0]    rsp_key_out,
   output logic [chbs_pkg::LEN_PORT_W-1:0]    rsp_longest_length,
   output logic [chbs_pkg::CNT_PORT_W-1:0]    rsp_longest_count,
   output logic [chbs_pkg::LEN_PORT_W-1:0]    rsp_shortest_length,
   output logic [chbs_pkg::CNT_PORT_W-1:0]    rsp_shortest_count,
   output logic [chbs_pkg::TOT_PORT_W-1:0]    rsp_total_keys
);
   import chbs_pkg::*;

   localparam int KW     = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int DEPTH  = BUCKETS * CHAIN_DEPTH;
   localparam int AW     = $clog2(DEPTH);
   localparam int LEN_W  = $clog2(CHAIN_DEPTH + 1);
   localparam int TOT_W  = $clog2(DEPTH + 1);
   localparam int SCAN_W = $clog2(BUCKETS + 1);
   localparam logic [AW-1:0] ROW = AW'(CHAIN_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_HASH  = 6'b000010,
      S_ISSUE = 6'b000100,
      S_LOOK  = 6'b001000,
      S_SCAN  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic                  op_ff, op_in;
   logic [BKT_W-1:0]      bidx_ff, bidx_in;
   logic                  oor_ff, oor_in;
   logic [BKT_PORT_W-1:0] bkt_ff, bkt_in;
   logic [POS_PORT_W-1:0] pos_ff, pos_in;
   logic [KW-1:0]         hkey_ff, hkey_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [KW-1:0]         keyout_ff, keyout_in;
   logic [POS_PORT_W-1:0] posout_ff, posout_in;
   logic [TOT_W-1:0]      total_ff, total_in;
   logic [SCAN_W-1:0]     scan_ff, scan_in;
   logic                  smp_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [BKT_PORT_W-1:0] rsp_bkt_ff, rsp_bkt_in;
   logic [POS_PORT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [KW-1:0]         rsp_key_ff, rsp_key_in;
   stats_type             rsp_stats_ff, rsp_stats_in;
   logic [TOT_W-1:0]      rsp_total_ff, rsp_total_in;

   logic                  mod_start, mod_done;
   logic [BKT_W-1:0]      mod_rem;
   logic [AW-1:0]         key_off, key_addr;
   logic                  key_we;
   logic [KW-1:0]         key_rdata;
   logic [BKT_W-1:0]      len_addr;
   logic                  len_we;
   logic [LEN_W-1:0]      len_wdata, len_rdata;
   logic                  stat_clr, scan_issue;
   stats_type             stats;

   assign key_addr  = AW'(bidx_ff) * ROW + key_off;
   assign len_wdata = len_rdata + LEN_W'(1);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      bidx_in       = bidx_ff;
      oor_in        = oor_ff;
      bkt_in        = bkt_ff;
      pos_in        = pos_ff;
      hkey_in       = hkey_ff;
      status_in     = status_ff;
      keyout_in     = keyout_ff;
      posout_in     = posout_ff;
      total_in      = total_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_bkt_in    = rsp_bkt_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_stats_in  = rsp_stats_ff;
      rsp_total_in  = rsp_total_ff;
      mod_start     = 1'b0;
      key_off       = AW'(pos_ff);
      key_we        = 1'b0;
      len_addr      = bidx_ff;
      len_we        = 1'b0;
      stat_clr      = 1'b0;
      scan_issue    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_type;
               hkey_in = KW'(req_key_in);
               bkt_in  = req_bucket_sel;
               pos_in  = req_position_sel;
               bidx_in = BKT_W'(req_bucket_sel);
               oor_in  = (int'(req_bucket_sel) >= BUCKETS);
               if (req_type == REQ_INSERT) begin
                  mod_start = 1'b1;
                  state_in  = S_HASH;
               end else begin
                  state_in  = S_ISSUE;
               end
            end
         end
         S_HASH: begin
            if (mod_done) begin
               bidx_in  = mod_rem;
               bkt_in   = BKT_PORT_W'(mod_rem);
               oor_in   = 1'b0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_LOOK;
         end
         S_LOOK: begin
            stat_clr  = 1'b1;
            scan_in   = '0;
            keyout_in = '0;
            posout_in = pos_ff;
            state_in  = S_SCAN;
            if (op_ff == REQ_INSERT) begin
               if (int'(len_rdata) >= CHAIN_DEPTH) begin
                  status_in = ST_FULL;
                  posout_in = '0;
               end else begin
                  status_in = ST_OK;
                  posout_in = POS_PORT_W'(len_rdata);
                  key_off   = AW'(len_rdata);
                  key_we    = 1'b1;
                  len_we    = 1'b1;
                  total_in  = total_ff + TOT_W'(1);
               end
            end else begin
               if (oor_ff || (int'(pos_ff) >= int'(len_rdata))) begin
                  status_in = ST_EMPTY;
               end else begin
                  status_in = ST_OK;
                  keyout_in = key_rdata;
               end
            end
         end
         S_SCAN: begin
            if (int'(scan_ff) < BUCKETS) begin
               len_addr   = BKT_W'(scan_ff);
               scan_in    = scan_ff + SCAN_W'(1);
               scan_issue = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_bkt_in    = bkt_ff;
               rsp_pos_in    = posout_ff;
               rsp_key_in    = keyout_ff;
               rsp_stats_in  = stats;
               rsp_total_in  = total_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         scan_ff      <= '0;
         smp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         scan_ff      <= scan_in;
         smp_ff       <= scan_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      bidx_ff       <= bidx_in;
      oor_ff        <= oor_in;
      bkt_ff        <= bkt_in;
      pos_ff        <= pos_in;
      hkey_ff       <= hkey_in;
      status_ff     <= status_in;
      keyout_ff     <= keyout_in;
      posout_ff     <= posout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bkt_ff    <= rsp_bkt_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_stats_ff  <= rsp_stats_in;
      rsp_total_ff  <= rsp_total_in;
   end

   chbs_mod_unit #(
      .BUCKETS (BUCKETS),
      .KEY_W   (KW)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .key   (KW'(req_key_in)),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   chbs_key_mem #(
      .DEPTH (DEPTH),
      .KEY_W (KW)
   ) u_key_mem (
      .clock (clock),
      .addr  (key_addr),
      .we    (key_we),
      .wdata (hkey_ff),
      .rdata (key_rdata)
   );

   chbs_len_mem #(
      .BUCKETS (BUCKETS),
      .LEN_W   (LEN_W)
   ) u_len_mem (
      .clock (clock),
      .reset (reset),
      .addr  (len_addr),
      .we    (len_we),
      .wdata (len_wdata),
      .rdata (len_rdata)
   );

   chbs_stats #(
      .BUCKETS (BUCKETS),
      .LEN_W   (LEN_W)
   ) u_stats (
      .clock  (clock),
      .reset  (reset),
      .clr    (stat_clr),
      .sample (smp_ff),
      .len    (len_rdata),
      .stats  (stats)
   );

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_bucket_out      = rsp_bkt_ff;
   assign rsp_position_out    = rsp_pos_ff;
   assign rsp_key_out         = KEY_PORT_W'(rsp_key_ff);
   assign rsp_longest_length  = rsp_stats_ff.longest_len;
   assign rsp_longest_count   = rsp_stats_ff.longest_cnt;
   assign rsp_shortest_length = rsp_stats_ff.shortest_len;
   assign rsp_shortest_count  = rsp_stats_ff.shortest_cnt;
   assign rsp_total_keys      = TOT_PORT_W'(rsp_total_ff);

endmodule

// File: rtl/chbs_checker.sv
// Port-level checks for the chained hash bucket store, bound to the top level.
// Depends on chbs_pkg and chained_hash_bucket_store_top.
module chbs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_type,
   input logic [chbs_pkg::KEY_PORT_W-1:0] req_key_in,
   input logic [chbs_pkg::BKT_PORT_W-1:0] req_bucket_sel,
   input logic [chbs_pkg::POS_PORT_W-1:0] req_position_sel,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [chbs_pkg::STATUS_W-1:0]   rsp_status,
   input logic [chbs_pkg::BKT_PORT_W-1:0] rsp_bucket_out,
   input logic [chbs_pkg::POS_PORT_W-1:0] rsp_position_out,
   input logic [chbs_pkg::KEY_PORT_W-1:0] rsp_key_out,
   input logic [chbs_pkg::LEN_PORT_W-1:0] rsp_longest_length,
   input logic [chbs_pkg::CNT_PORT_W-1:0] rsp_longest_count,
   input logic [chbs_pkg::LEN_PORT_W-1:0] rsp_shortest_length,
   input logic [chbs_pkg::CNT_PORT_W-1:0] rsp_shortest_count,
   input logic [chbs_pkg::TOT_PORT_W-1:0] rsp_total_keys
);
   import chbs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_key_out) && $stable(rsp_total_keys))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (rsp_key_out == '0)
         && (rsp_position_out == '0))
      else $error("dropped insert reports key or position");

   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_key_out == '0))
      else $error("failed read returns a key");

endmodule

bind chained_hash_bucket_store_top chbs_checker u_chbs_checker (.*);

// File: tb/tb_chained_hash_bucket_store_top.sv
// Self-checking testbench for chained_hash_bucket_store_top: directed table, then random traffic.
// Depends on chbs_pkg and the block's RTL; a local hash table model predicts all but the fixed directed results.
// Both channels idle and stall at random; results are compared field by field in order.
module tb_chained_hash_bucket_store_top;
   import chbs_pkg::*;

   localparam int NUM_BUCKETS  = 7;
   localparam int CHAIN_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 1625;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic                  kind;
      logic [KEY_PORT_W-1:0] key;
      logic [BKT_PORT_W-1:0] bucket;
      logic [POS_PORT_W-1:0] position;
   } hash_req_type;

   typedef struct {
      logic [STATUS_W-1:0]   status;
      logic [BKT_PORT_W-1:0] bucket;
      logic [POS_PORT_W-1:0] position;
      logic [KEY_PORT_W-1:0] key;
      logic [LEN_PORT_W-1:0] longest_len;
      logic [CNT_PORT_W-1:0] longest_cnt;
      logic [LEN_PORT_W-1:0] shortest_len;
      logic [CNT_PORT_W-1:0] shortest_cnt;
      logic [TOT_PORT_W-1:0] total;
   } hash_rsp_type;

   typedef struct {
      hash_req_type req;
      bit           fixed;
      hash_rsp_type rsp;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = REQ_INSERT;
   logic [KEY_PORT_W-1:0] req_key_in = '0;
   logic [BKT_PORT_W-1:0] req_bucket_sel = '0;
   logic [POS_PORT_W-1:0] req_position_sel = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [BKT_PORT_W-1:0] rsp_bucket_out;
   logic [POS_PORT_W-1:0] rsp_position_out;
   logic [KEY_PORT_W-1:0] rsp_key_out;
   logic [LEN_PORT_W-1:0] rsp_longest_length;
   logic [CNT_PORT_W-1:0] rsp_longest_count;
   logic [LEN_PORT_W-1:0] rsp_shortest_length;
   logic [CNT_PORT_W-1:0] rsp_shortest_count;
   logic [TOT_PORT_W-1:0] rsp_total_keys;

   // table model
   logic [KEY_PORT_W-1:0] stored_keys [NUM_BUCKETS][CHAIN_DEPTH];
   int unsigned           chain_len [NUM_BUCKETS];
   int unsigned           key_count;

   hash_rsp_type pending_results [$];
   plan_row_type plan [$];
   int unsigned  mismatches;
   int unsigned  cycles;
   bit           no_idle;

   chained_hash_bucket_store_top #(
      .BUCKETS     (NUM_BUCKETS),
      .CHAIN_DEPTH (CHAIN_DEPTH),
      .KEY_BITS    (KEY_PORT_W)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_key_in          (req_key_in),
      .req_bucket_sel      (req_bucket_sel),
      .req_position_sel    (req_position_sel),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_bucket_out      (rsp_bucket_out),
      .rsp_position_out    (rsp_position_out),
      .rsp_key_out         (rsp_key_out),
      .rsp_longest_length  (rsp_longest_length),
      .rsp_longest_count   (rsp_longest_count),
      .rsp_shortest_length (rsp_shortest_length),
      .rsp_shortest_count  (rsp_shortest_count),
      .rsp_total_keys      (rsp_total_keys)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic hash_req_type make_req(logic kind, int key, int bucket, int position);
      hash_req_type r;
      r.kind     = kind;
      r.key      = KEY_PORT_W'(key);
      r.bucket   = BKT_PORT_W'(bucket);
      r.position = POS_PORT_W'(position);
      return r;
   endfunction

   function automatic hash_rsp_type make_rsp(logic [STATUS_W-1:0] st, int bucket, int position,
                                            int key, int ll, int lc, int sl, int sc, int tot);
      hash_rsp_type o;
      o.status       = st;
      o.bucket       = BKT_PORT_W'(bucket);
      o.position     = POS_PORT_W'(position);
      o.key          = KEY_PORT_W'(key);
      o.longest_len  = LEN_PORT_W'(ll);
      o.longest_cnt  = CNT_PORT_W'(lc);
      o.shortest_len = LEN_PORT_W'(sl);
      o.shortest_cnt = CNT_PORT_W'(sc);
      o.total        = TOT_PORT_W'(tot);
      return o;
   endfunction

   function automatic void add_row(hash_req_type r, bit fixed, hash_rsp_type o);
      plan_row_type row;
      row.req   = r;
      row.fixed = fixed;
      row.rsp   = o;
      plan.push_back(row);
   endfunction

   // applies one request to the model and returns its result, statistics after the update
   function automatic hash_rsp_type apply_to_table(hash_req_type r);
      hash_rsp_type o;
      int unsigned  b;
      int unsigned  hi;
      int unsigned  lo;
      int unsigned  hi_n;
      int unsigned  lo_n;
      o = make_rsp(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0);
      if (r.kind == REQ_INSERT) begin
         b        = r.key % NUM_BUCKETS;
         o.bucket = BKT_PORT_W'(b);
         if (chain_len[b] >= CHAIN_DEPTH) begin
            o.status = ST_FULL;
         end else begin
            o.position                  = POS_PORT_W'(chain_len[b]);
            stored_keys[b][chain_len[b]] = r.key;
            chain_len[b]++;
            key_count++;
         end
      end else begin
         o.bucket   = r.bucket;
         o.position = r.position;
         if (r.bucket >= NUM_BUCKETS || r.position >= chain_len[r.bucket]) begin
            o.status = ST_EMPTY;
         end else begin
            o.key = stored_keys[r.bucket][r.position];
         end
      end
      hi = chain_len[0];
      lo = chain_len[0];
      foreach (chain_len[i]) begin
         if (chain_len[i] > hi) hi = chain_len[i];
         if (chain_len[i] < lo) lo = chain_len[i];
      end
      hi_n = 0;
      lo_n = 0;
      foreach (chain_len[i]) begin
         if (chain_len[i] == hi) hi_n++;
         if (chain_len[i] == lo) lo_n++;
      end
      o.longest_len  = LEN_PORT_W'(hi);
      o.longest_cnt  = CNT_PORT_W'(hi_n);
      o.shortest_len = LEN_PORT_W'(lo);
      o.shortest_cnt = CNT_PORT_W'(lo_n);
      o.total        = TOT_PORT_W'(key_count);
      return o;
   endfunction

   // mostly reads of stored entries, some inserts, some reads anywhere
   function automatic hash_req_type random_request();
      hash_req_type r;
      int           b;
      r = make_req(REQ_READ, $urandom_range(65535), $urandom_range(7), $urandom_range(15));
      if ($urandom_range(99) < 7) begin
         r.kind = REQ_INSERT;
      end else if (key_count != 0 && $urandom_range(99) < 80) begin
         do b = $urandom_range(NUM_BUCKETS - 1); while (chain_len[b] == 0);
         r.bucket   = BKT_PORT_W'(b);
         r.position = POS_PORT_W'($urandom_range(chain_len[b] - 1));
      end
      return r;
   endfunction

   task automatic send_request(hash_req_type r, bit fixed, hash_rsp_type typed);
      hash_rsp_type predicted;
      if (!no_idle && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 24);
      end
      req_valid        <= 1'b1;
      req_type         <= r.kind;
      req_key_in       <= r.key;
      req_bucket_sel   <= r.bucket;
      req_position_sel <= r.position;
      do @(posedge clock); while (!req_ready);
      predicted = apply_to_table(r);
      pending_results.push_back(fixed ? typed : predicted);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      hash_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 24);
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no request outstanding");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("bucket_out", 32'(want.bucket), 32'(rsp_bucket_out));
               check_field("position_out", 32'(want.position), 32'(rsp_position_out));
               check_field("key_out", 32'(want.key), 32'(rsp_key_out));
               check_field("longest_length", 32'(want.longest_len),
                           32'(rsp_longest_length));
               check_field("longest_count", 32'(want.longest_cnt),
                           32'(rsp_longest_count));
               check_field("shortest_length", 32'(want.shortest_len),
                           32'(rsp_shortest_length));
               check_field("shortest_count", 32'(want.shortest_cnt),
                           32'(rsp_shortest_count));
               check_field("total_keys", 32'(want.total), 32'(rsp_total_keys));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      hash_rsp_type none;
      none = make_rsp(ST_OK, 0, 0, 0, 0, 0, 0, 0, 0);

      // empty table, full-width key extremes, read-back, reads past the end
      add_row(make_req(REQ_READ, 0, 0, 0), 1, make_rsp(ST_EMPTY, 0, 0, 0, 0, 7, 0, 7, 0));
      add_row(make_req(REQ_READ, 'h5A5A, 7, 15), 1,
              make_rsp(ST_EMPTY, 7, 15, 0, 0, 7, 0, 7, 0));
      add_row(make_req(REQ_INSERT, 0, 5, 9), 1, make_rsp(ST_OK, 0, 0, 0, 1, 1, 0, 6, 1));
      add_row(make_req(REQ_INSERT, 65535, 0, 0), 1, make_rsp(ST_OK, 1, 0, 0, 1, 2, 0, 5, 2));
      add_row(make_req(REQ_READ, 0, 1, 0), 1, make_rsp(ST_OK, 1, 0, 65535, 1, 2, 0, 5, 2));
      add_row(make_req(REQ_READ, 65535, 0, 0), 1, make_rsp(ST_OK, 0, 0, 0, 1, 2, 0, 5, 2));
      add_row(make_req(REQ_READ, 0, 1, 1), 1, make_rsp(ST_EMPTY, 1, 1, 0, 1, 2, 0, 5, 2));
      // fill bucket 2, then overflow it
      for (int k = 0; k < CHAIN_DEPTH; k++)
         add_row(make_req(REQ_INSERT, 2 + 7 * 583 * k, 0, 0), 0, none);
      add_row(make_req(REQ_INSERT, 65529, 0, 0), 0, none);
      add_row(make_req(REQ_READ, 0, 2, 15), 0, none);
      add_row(make_req(REQ_READ, 0, 2, 0), 0, none);
      add_row(make_req(REQ_READ, 0, 6, 15), 0, none);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) send_request(plan[i].req, plan[i].fixed, plan[i].rsp);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = (n >= 400 && n < 700);
         if (n == 800) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         send_request(random_request(), 0, none);
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
